[rtl/ple_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg - shared types and constants of the positional list engine
// Operation and status codes, field widths of the stream payloads and the
// command that the top level broadcasts along the row of list cells.
// ----------------------------------------------------------------------------
package ple_pkg;

	// Payload field widths
	localparam int OP_W    = 2;
	localparam int POS_W   = 7;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int LEN_W   = 7;

	// Stream bus widths
	localparam int S_USER_W = OP_W;
	localparam int S_DATA_W = 40;   // position + value = 39 bits, padded
	localparam int M_DATA_W = 56;   // 2 + 32 + 7 + 7 + 1 = 49 bits, padded

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_FIND   = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STATUS_OK     = 2'd0,
		STATUS_BOUNDS = 2'd1,
		STATUS_FULL   = 2'd2
	} status_t;

	// Command broadcast to every cell; strobes are high only in the
	// cycle a request is accepted and passed its checks.
	typedef struct packed {
		logic             ins;    // insert at pos0, shift up from there
		logic             del;    // delete at pos0, shift down from there
		logic             rd;     // flag the cell at pos0 for read-out
		logic             srch;   // flag live cells that match x
		logic [POS_W-1:0] pos0;   // zero-based position
		logic [VAL_W-1:0] x;      // value to insert or to look for
	} cell_cmd_t;

endpackage

[rtl/ple_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_cell - one list entry
// Holds one 32-bit entry, takes its left or right neighbor's word on insert
// or delete, and raises a hit flag for read-out or search.
// ----------------------------------------------------------------------------
module ple_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  logic                     clk,
	input  ple_pkg::cell_cmd_t       cmd,
	input  logic [CNT_W-1:0]         count,
	input  logic [ple_pkg::VAL_W-1:0] left,
	input  logic [ple_pkg::VAL_W-1:0] right,
	output logic [ple_pkg::VAL_W-1:0] data,
	output logic                     hit
);

	localparam logic [31:0] IdxL = 32'(IDX);

	logic [ple_pkg::VAL_W-1:0] data_q;
	logic [31:0]               pos_w;
	logic                      live;

	assign pos_w = 32'(cmd.pos0);
	assign live  = IdxL < 32'(count);

	// Shift: insert pulls from the left, delete pulls from the right
	always_ff @(posedge clk) begin
		if (cmd.ins && IdxL >= pos_w) begin
			data_q <= (IdxL == pos_w) ? cmd.x : left;
		end else if (cmd.del && IdxL >= pos_w) begin
			data_q <= right;
		end
	end

	// Hit flag for the read-out tree
	assign hit  = (cmd.rd && IdxL == pos_w) || (cmd.srch && live && data_q == cmd.x);
	assign data = data_q;

endmodule

[rtl/ple_reduce.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_reduce - registered read-out tree
// Captures the hit flags and words of all cells, then picks the lowest
// flagged cell one tree level per cycle; one register per tree node.
// ----------------------------------------------------------------------------
module ple_reduce #(
	parameter int CAPACITY = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [CAPACITY-1:0]       leaf_hit,
	input  logic [ple_pkg::VAL_W-1:0] leaf_data [CAPACITY],
	output logic                      res_valid,
	output logic                      res_hit,
	output logic [$clog2(CAPACITY)-1:0] res_idx,
	output logic [ple_pkg::VAL_W-1:0] res_data
);

	localparam int LVL = $clog2(CAPACITY);
	localparam int N2  = 1 << LVL;

	logic                      node_hit_q [1:2*N2-1];
	logic [ple_pkg::VAL_W-1:0] node_dat_q [1:2*N2-1];
	logic [LVL-1:0]            node_idx_q [1:2*N2-1];
	logic [LVL:0]              vld_q;

	// Leaves load on a request; inner nodes keep the lower flagged child
	always_ff @(posedge clk) begin
		if (load) begin
			for (int j = 0; j < N2; j++) begin
				if (j < CAPACITY) begin
					node_hit_q[N2+j] <= leaf_hit[j];
					node_dat_q[N2+j] <= leaf_data[j];
				end else begin
					node_hit_q[N2+j] <= 1'b0;
					node_dat_q[N2+j] <= '0;
				end
				node_idx_q[N2+j] <= LVL'(j);
			end
		end
		for (int n = 1; n < N2; n++) begin
			if (node_hit_q[2*n]) begin
				node_hit_q[n] <= 1'b1;
				node_dat_q[n] <= node_dat_q[2*n];
				node_idx_q[n] <= node_idx_q[2*n];
			end else begin
				node_hit_q[n] <= node_hit_q[2*n+1];
				node_dat_q[n] <= node_dat_q[2*n+1];
				node_idx_q[n] <= node_idx_q[2*n+1];
			end
		end
	end

	// Valid marker walks with the tree levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LVL-1:0], load};
		end
	end

	assign res_valid = vld_q[LVL];
	assign res_hit   = node_hit_q[1];
	assign res_idx   = node_idx_q[1];
	assign res_data  = node_dat_q[1];

endmodule

[rtl/positional_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine - bounded ordered list with 1-based positions
// Insert, delete, find-by-position and search-by-value over a row of cells.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle. The read-out tree captures
// the cells at acceptance and climbs one level per cycle, and the result is
// registered once more behind the tree root. The block stays busy until the
// result is taken, and the next request is taken in the cycle after that.
// Inserts and deletes shift all cells from the given position upward at once
// in the acceptance cycle. The tree returns the found or removed word and the
// first matching position. Entries need no clearing after reset.
// ----------------------------------------------------------------------------
module positional_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [ple_pkg::S_DATA_W-1:0] s_tdata,   // position[6:0], value[38:7]
	input  logic [ple_pkg::S_USER_W-1:0] s_tuser,   // operation[1:0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ple_pkg::M_DATA_W-1:0] m_tdata    // status[1:0], value_out[33:2],
	                                                // found_position[40:34],
	                                                // list_length[47:41], is_empty[48]
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int AW    = $clog2(CAPACITY);

	// Request fields
	ple_pkg::op_t                 op;
	logic [ple_pkg::POS_W-1:0]    pos;
	logic [ple_pkg::VAL_W-1:0]    val;
	logic                         s_acc;
	logic                         m_acc;

	// Control state
	logic                         busy_q;
	logic [CNT_W-1:0]             count_q;
	ple_pkg::status_t             status_q;
	logic                         rd_q;
	logic                         srch_q;

	// Decode
	ple_pkg::cell_cmd_t           cmd;
	ple_pkg::status_t             status_d;
	logic                         ins_ok;
	logic                         del_ok;
	logic                         rd_ok;
	logic [31:0]                  pos_w;
	logic [31:0]                  cnt_w;

	// Cells and tree
	logic [ple_pkg::VAL_W-1:0]    cell_data [CAPACITY];
	logic [CAPACITY-1:0]          cell_hit;
	logic                         res_valid;
	logic                         res_hit;
	logic [AW-1:0]                res_idx;
	logic [ple_pkg::VAL_W-1:0]    res_data;
	logic [31:0]                  found_w;

	// Output register
	logic                         out_valid_q;
	ple_pkg::status_t             out_status_q;
	logic [ple_pkg::VAL_W-1:0]    out_value_q;
	logic [ple_pkg::POS_W-1:0]    out_found_q;
	logic [ple_pkg::LEN_W-1:0]    out_len_q;
	logic                         out_empty_q;

	assign op    = ple_pkg::op_t'(s_tuser[ple_pkg::OP_W-1:0]);
	assign pos   = s_tdata[6:0];
	assign val   = s_tdata[38:7];
	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	assign s_tready = !busy_q;

	// Bounds and capacity checks
	assign pos_w = 32'(pos);
	assign cnt_w = 32'(count_q);

	always_comb begin
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		rd_ok    = 1'b0;
		status_d = ple_pkg::STATUS_OK;
		unique case (op)
			ple_pkg::OP_INSERT: begin
				if (pos_w < 32'd1 || pos_w > cnt_w + 32'd1) begin
					status_d = ple_pkg::STATUS_BOUNDS;
				end else if (cnt_w == 32'(CAPACITY)) begin
					status_d = ple_pkg::STATUS_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			ple_pkg::OP_DELETE: begin
				if (pos_w < 32'd1 || pos_w > cnt_w) begin
					status_d = ple_pkg::STATUS_BOUNDS;
				end else begin
					del_ok = 1'b1;
					rd_ok  = 1'b1;
				end
			end
			ple_pkg::OP_FIND: begin
				if (pos_w < 32'd1 || pos_w > cnt_w) begin
					status_d = ple_pkg::STATUS_BOUNDS;
				end else begin
					rd_ok = 1'b1;
				end
			end
			ple_pkg::OP_SEARCH: begin
				status_d = ple_pkg::STATUS_OK;
			end
			default: begin
				status_d = ple_pkg::STATUS_OK;
			end
		endcase
	end

	// Broadcast command, live only in the acceptance cycle
	always_comb begin
		cmd.ins  = s_acc && ins_ok;
		cmd.del  = s_acc && del_ok;
		cmd.rd   = s_acc && rd_ok;
		cmd.srch = s_acc && (op == ple_pkg::OP_SEARCH);
		cmd.pos0 = pos - ple_pkg::POS_W'(1);
		cmd.x    = val;
	end

	// Row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ple_pkg::VAL_W-1:0] left;
		logic [ple_pkg::VAL_W-1:0] right;

		if (i == 0) begin : g_first
			assign left = val;
		end else begin : g_mid_l
			assign left = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = cell_data[i];
		end else begin : g_mid_r
			assign right = cell_data[i+1];
		end

		ple_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.count (count_q),
			.left  (left),
			.right (right),
			.data  (cell_data[i]),
			.hit   (cell_hit[i])
		);
	end

	// Read-out tree
	ple_reduce #(
		.CAPACITY (CAPACITY)
	) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s_acc),
		.leaf_hit  (cell_hit),
		.leaf_data (cell_data),
		.res_valid (res_valid),
		.res_hit   (res_hit),
		.res_idx   (res_idx),
		.res_data  (res_data)
	);

	// Length, busy flag and per-request control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			count_q  <= '0;
			status_q <= ple_pkg::STATUS_OK;
			rd_q     <= 1'b0;
			srch_q   <= 1'b0;
		end else begin
			if (s_acc) begin
				busy_q   <= 1'b1;
				status_q <= status_d;
				rd_q     <= rd_ok;
				srch_q   <= (op == ple_pkg::OP_SEARCH);
				if (ins_ok) begin
					count_q <= count_q + CNT_W'(1);
				end else if (del_ok) begin
					count_q <= count_q - CNT_W'(1);
				end
			end else if (m_acc) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Result register
	assign found_w = 32'(res_idx) + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_status_q <= status_q;
			out_value_q  <= rd_q ? res_data : '0;
			out_found_q  <= (srch_q && res_hit) ? found_w[ple_pkg::POS_W-1:0] : '0;
			out_len_q    <= ple_pkg::LEN_W'(count_q);
			out_empty_q  <= (count_q == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_empty_q, out_len_q, out_found_q, out_value_q, out_status_q};

endmodule

[rtl/ple_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_checker - port-level checks for the positional list engine
// Watches the two stream channels: one request in flight, one result per
// request, consistent length and empty flag.
// ----------------------------------------------------------------------------
module ple_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [ple_pkg::M_DATA_W-1:0] m_tdata
);

	// No new request while a result waits
	a_no_req_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("request accepted while a result is pending");

	// One request at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request taken while busy");

	// One result per request
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> !m_tvalid)
		else $error("result repeated");

	// Empty flag agrees with the length
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[48] == (m_tdata[47:41] == 7'd0)))
		else $error("empty flag disagrees with length");

	// Stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);

[test/positional_list_engine_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_test - self-checking bench for the positional list
// A short table of directed requests covers an empty list, bad positions
// and extreme values. It is followed by random insert, delete, find and
// search traffic that swings the list between empty and full. Each result is
// compared field by field with the table's expected result or a behavioral
// list model, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module positional_list_engine_test;
	import ple_pkg::*;

	localparam int LIST_CAP       = 64;
	localparam int RANDOM_PER_PH  = 257;
	localparam int DRAIN_CYCLES   = 24;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_MAX     = 10;

	typedef struct packed {
		status_t          status;
		logic [VAL_W-1:0] value_out;
		logic [POS_W-1:0] found_pos;
		logic [LEN_W-1:0] length;
		logic             empty;
	} list_result_t;

	// One directed request; typed = 1 means the expected result is given here
	typedef struct packed {
		op_t              op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		logic             typed;
		list_result_t     want;
	} directed_req_t;

	localparam int DIRECTED_N = 24;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic [S_USER_W-1:0] s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	// List model state
	logic [VAL_W-1:0] list_store [LIST_CAP];
	int               list_len;

	list_result_t pending_results [$];
	int           mismatches  = 0;
	int           idle_pct    = 0;
	int           stall_pct   = 0;
	int           quiet_cycles = 0;

	logic [VAL_W-1:0] value_pool [8] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
		32'h0000_0001, 32'h0000_002A, 32'hDEAD_BEEF, 32'h5555_AAAA
	};

	directed_req_t directed_reqs [DIRECTED_N] = '{
		// empty list: every positional access is out of bounds
		'{OP_FIND,   7'd1,   32'd0,         1'b1, '{STATUS_BOUNDS, 32'd0, 7'd0, 7'd0, 1'b1}},
		'{OP_DELETE, 7'd1,   32'd0,         1'b1, '{STATUS_BOUNDS, 32'd0, 7'd0, 7'd0, 1'b1}},
		'{OP_INSERT, 7'd0,   32'd5,         1'b1, '{STATUS_BOUNDS, 32'd0, 7'd0, 7'd0, 1'b1}},
		'{OP_INSERT, 7'd2,   32'd5,         1'b1, '{STATUS_BOUNDS, 32'd0, 7'd0, 7'd0, 1'b1}},
		'{OP_SEARCH, 7'd0,   32'd0,         1'b1, '{STATUS_OK,     32'd0, 7'd0, 7'd0, 1'b1}},
		// build [min, max, 0]
		'{OP_INSERT, 7'd1,   32'h7FFF_FFFF, 1'b1, '{STATUS_OK,     32'd0, 7'd0, 7'd1, 1'b0}},
		'{OP_INSERT, 7'd1,   32'h8000_0000, 1'b1, '{STATUS_OK,     32'd0, 7'd0, 7'd2, 1'b0}},
		'{OP_INSERT, 7'd3,   32'd0,         1'b1, '{STATUS_OK,     32'd0, 7'd0, 7'd3, 1'b0}},
		'{OP_INSERT, 7'd127, 32'd1,         1'b1, '{STATUS_BOUNDS, 32'd0, 7'd0, 7'd3, 1'b0}},
		'{OP_FIND,   7'd1,   32'd0,         1'b0, '0},
		'{OP_FIND,   7'd3,   32'hFFFF_FFFF, 1'b0, '0},
		'{OP_FIND,   7'd4,   32'd0,         1'b1, '{STATUS_BOUNDS, 32'd0, 7'd0, 7'd3, 1'b0}},
		'{OP_FIND,   7'd0,   32'd0,         1'b1, '{STATUS_BOUNDS, 32'd0, 7'd0, 7'd3, 1'b0}},
		'{OP_SEARCH, 7'd127, 32'h7FFF_FFFF, 1'b0, '0},
		'{OP_SEARCH, 7'd5,   32'h0001_2345, 1'b0, '0},
		// duplicates: search must return the first match
		'{OP_INSERT, 7'd2,   32'hFFFF_FFFF, 1'b0, '0},
		'{OP_INSERT, 7'd5,   32'hFFFF_FFFF, 1'b0, '0},
		'{OP_SEARCH, 7'd0,   32'hFFFF_FFFF, 1'b0, '0},
		'{OP_DELETE, 7'd0,   32'd0,         1'b1, '{STATUS_BOUNDS, 32'd0, 7'd0, 7'd5, 1'b0}},
		'{OP_DELETE, 7'd127, 32'd0,         1'b1, '{STATUS_BOUNDS, 32'd0, 7'd0, 7'd5, 1'b0}},
		'{OP_DELETE, 7'd6,   32'd0,         1'b1, '{STATUS_BOUNDS, 32'd0, 7'd0, 7'd5, 1'b0}},
		'{OP_DELETE, 7'd2,   32'd0,         1'b0, '0},
		'{OP_DELETE, 7'd1,   32'd0,         1'b0, '0},
		'{OP_FIND,   7'd127, 32'd0,         1'b1, '{STATUS_BOUNDS, 32'd0, 7'd0, 7'd3, 1'b0}}
	};

	positional_list_engine #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),    // position[6:0], value[38:7]
		.s_tuser (s_tuser),    // operation[1:0]
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)     // status[1:0], value_out[33:2], found_position[40:34],
		                       // list_length[47:41], is_empty[48]
	);

	always #1 clk = ~clk;

	// Apply one request to the list model and return its result
	function automatic list_result_t apply_list_op(op_t op, logic [POS_W-1:0] pos,
			logic [VAL_W-1:0] val);
		list_result_t res;
		int k;
		res = '{STATUS_OK, '0, '0, '0, 1'b0};
		k = int'(pos);
		case (op)
			OP_INSERT: begin
				if (k < 1 || k > list_len + 1)
					res.status = STATUS_BOUNDS;
				else if (list_len >= LIST_CAP)
					res.status = STATUS_FULL;
				else begin
					for (int i = list_len; i >= k; i--)
						list_store[i] = list_store[i-1];
					list_store[k-1] = val;
					list_len++;
				end
			end
			OP_DELETE: begin
				if (k < 1 || k > list_len)
					res.status = STATUS_BOUNDS;
				else begin
					res.value_out = list_store[k-1];
					for (int i = k; i < list_len; i++)
						list_store[i-1] = list_store[i];
					list_len--;
				end
			end
			OP_FIND: begin
				if (k < 1 || k > list_len)
					res.status = STATUS_BOUNDS;
				else
					res.value_out = list_store[k-1];
			end
			default: begin
				for (int i = 0; i < list_len; i++) begin
					if (list_store[i] == val && res.found_pos == '0)
						res.found_pos = POS_W'(i + 1);
				end
			end
		endcase
		res.length = LEN_W'(list_len);
		res.empty  = (list_len == 0);
		return res;
	endfunction

	// Offer one request, wait for its acceptance, then maybe leave a gap
	task automatic send_request(op_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
			logic typed, list_result_t want);
		list_result_t predicted;
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, val, pos};
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
		predicted = apply_list_op(op, pos, val);
		pending_results.push_back(typed ? want : predicted);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	// Result checker and receiver stall generator
	always @(posedge clk) begin
		list_result_t want;
		list_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status    = status_t'(m_tdata[1:0]);
			got.value_out = m_tdata[33:2];
			got.found_pos = m_tdata[40:34];
			got.length    = m_tdata[47:41];
			got.empty     = m_tdata[48];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: result with no request pending: %p", $realtime, got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: mismatch expected %p actual %p",
							$realtime, want, got);
				end
			end
		end
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: no request and no result taken for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		op_t              op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		logic             grow;
		int               roll;
		list_len = 0;
		grow     = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests, no idling
		foreach (directed_reqs[i])
			send_request(directed_reqs[i].op, directed_reqs[i].pos, directed_reqs[i].val,
				directed_reqs[i].typed, directed_reqs[i].want);

		// Random traffic: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			// hold off until the block has drained
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while (pending_results.size() != 0);
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 82; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 82; end
				default: begin idle_pct = 34; stall_pct = 34; end
			endcase
			for (int n = 0; n < RANDOM_PER_PH; n++) begin
				// swing between filling up and draining
				if (list_len == LIST_CAP && $urandom_range(3) == 0)
					grow = 1'b0;
				else if (list_len == 0 && $urandom_range(3) == 0)
					grow = 1'b1;
				roll = $urandom_range(99);
				if (roll < (grow ? 60 : 15))
					op = OP_INSERT;
				else if (roll < 75)
					op = grow ? OP_DELETE : OP_INSERT;
				else if (roll < 88)
					op = OP_FIND;
				else
					op = OP_SEARCH;
				if (op == OP_INSERT && roll >= 15 && roll < 75 && !grow)
					op = OP_DELETE;
				// values: pool for duplicates and extremes, else fully random
				if ($urandom_range(9) < 4)
					val = value_pool[$urandom_range(7)];
				else
					val = $urandom;
				// positions: mostly valid, sometimes anything
				if (op == OP_INSERT)
					pos = ($urandom_range(9) == 0) ? POS_W'($urandom_range(127))
						: POS_W'($urandom_range(list_len + 1, 1));
				else if (op == OP_SEARCH) begin
					pos = POS_W'($urandom_range(127));
					if (list_len > 0 && $urandom_range(1) == 0)
						val = list_store[$urandom_range(list_len - 1)];
				end else
					pos = (list_len == 0 || $urandom_range(9) == 0)
						? POS_W'($urandom_range(127))
						: POS_W'($urandom_range(list_len, 1));
				send_request(op, pos, val, 1'b0, '0);
			end
		end

		// Wait for the last results, then let the block settle
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
